/* rtl/core/pct_pkg.sv */
// shared constants and types for the priority count table
package pct_pkg;

	localparam int NUM_LEVELS_DEF  = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	// field widths fixed by the interface
	localparam int FUNC_W    = 2;
	localparam int PRIO_W    = 3;
	localparam int AMOUNT_W  = 16;
	localparam int OCOUNT_W  = 16;
	localparam int ACTIVE_W  = 8;
	localparam int LIMIT_W   = 16;

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_COUNT_LIMIT = 2'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INC = 2'd0,
		FUNC_DEC = 2'd1,
		FUNC_ADD = 2'd2,
		FUNC_SUB = 2'd3
	} func_t;

endpackage

/* rtl/core/priority_count_table.sv */
// per-level saturating counters in a small memory with an activity bitmap
//
//  port group  | dir | handshake                   | payload
//  ------------+-----+-----------------------------+-------------------------------------
//  config      | in  | psel/penable/pwrite, pready | paddr, pwdata, prdata (count_limit)
//  item        | in  | item_valid / item_ready     | func, prio, amount
//  result      | out | result_valid / result_ready | level_active, active_levels,
//              |     |                             | new_count, range_error
//
// an item is taken on item_valid && item_ready and the counter memory is read at
// that edge; the update is computed in the compute stage and is registered as the
// result. one item per cycle sustained while results are taken; a write-back to the
// entry read at the same edge is forwarded into the next item. the counter memory
// has no reset: per-entry valid bits make an unwritten counter read as zero. a
// stalled result holds the compute stage, and item_ready drops until it moves.
module priority_count_table #(
	parameter int NUM_LEVELS  = pct_pkg::NUM_LEVELS_DEF,
	parameter int COUNT_WIDTH = pct_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pct_pkg::PADDR_W-1:0]   paddr,
	input  logic [pct_pkg::PDATA_W-1:0]   pwdata,
	output logic [pct_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// items
	input  logic                          item_valid,
	output logic                          item_ready,
	input  pct_pkg::func_t                func,
	input  logic [pct_pkg::PRIO_W-1:0]    prio,
	input  logic [pct_pkg::AMOUNT_W-1:0]  amount,
	// results
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          level_active,
	output logic [pct_pkg::ACTIVE_W-1:0]  active_levels,
	output logic [pct_pkg::OCOUNT_W-1:0]  new_count,
	output logic                          range_error
);
	import pct_pkg::*;

	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CW = COUNT_WIDTH;
	localparam int BW = (NUM_LEVELS > ACTIVE_W) ? NUM_LEVELS : ACTIVE_W;
	localparam int XW = (CW > OCOUNT_W) ? CW : OCOUNT_W;

	// configuration register
	logic [LIMIT_W-1:0] count_limit_q;
	logic               cfg_wr;

	// counter memory and valid bits
	logic [CW-1:0]         cnt_mem [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] entry_vld_q;
	logic [NUM_LEVELS-1:0] bitmap_q;

	// compute stage
	logic          s1_valid_q;
	func_t         func_s1;
	logic          in_range_s1;
	logic [LW-1:0] idx_s1;
	logic [CW-1:0] amt_s1;
	logic [CW-1:0] rd_data_s1;
	logic          rd_vld_s1;
	logic          fwd_hit_s1;
	logic [CW-1:0] fwd_data_s1;

	// result register
	logic                 result_valid_q;
	logic                 level_active_q;
	logic [ACTIVE_W-1:0]  active_levels_q;
	logic [OCOUNT_W-1:0]  new_count_q;
	logic                 range_error_q;

	logic                  accept;
	logic                  fire;
	logic [LW-1:0]         acc_idx;
	logic                  acc_in_range;
	logic [CW-1:0]         lim;
	logic [CW-1:0]         cnt_cur;
	logic [CW-1:0]         cnt_next;
	logic                  err_next;
	logic                  set_bit;
	logic                  clr_bit;
	logic [NUM_LEVELS-1:0] bitmap_next;
	logic [BW-1:0]         bitmap_ext;
	logic [XW-1:0]         cnt_ext;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_COUNT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			count_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_COUNT_LIMIT) begin
			prdata = PDATA_W'(count_limit_q);
		end
	end

	// ---------------- handshake ----------------
	assign fire       = s1_valid_q && (!result_valid_q || result_ready);
	assign item_ready = !s1_valid_q || fire;
	assign accept     = item_valid && item_ready;

	assign acc_idx      = LW'(prio);
	assign acc_in_range = (32'(prio) < NUM_LEVELS);

	// ---------------- memory: read on accept, write on completion ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= cnt_mem[acc_idx];
		end
		if (fire && in_range_s1) begin
			cnt_mem[idx_s1] <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			bitmap_q    <= '0;
		end else if (fire && in_range_s1) begin
			entry_vld_q[idx_s1] <= 1'b1;
			bitmap_q            <= bitmap_next;
		end
	end

	// ---------------- compute stage registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			in_range_s1 <= acc_in_range;
			idx_s1      <= acc_idx;
			amt_s1      <= CW'(amount);
			rd_vld_s1   <= entry_vld_q[acc_idx];
			// entry written at this same edge: memory read returns the old value
			fwd_hit_s1  <= fire && in_range_s1 && (idx_s1 == acc_idx);
			fwd_data_s1 <= cnt_next;
		end
	end

	// ---------------- update logic ----------------
	assign lim = CW'(count_limit_q);

	always_comb begin
		if (fwd_hit_s1) begin
			cnt_cur = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cnt_cur = rd_data_s1;
		end else begin
			cnt_cur = '0;
		end
	end

	always_comb begin
		cnt_next = cnt_cur;
		err_next = 1'b0;
		set_bit  = 1'b0;
		clr_bit  = 1'b0;
		case (func_s1)
			FUNC_INC: begin
				set_bit = 1'b1;
				if (cnt_cur < lim) begin
					cnt_next = cnt_cur + CW'(1);
				end else begin
					cnt_next = lim;
					err_next = 1'b1;
				end
			end
			FUNC_DEC: begin
				if (cnt_cur != '0) begin
					cnt_next = cnt_cur - CW'(1);
				end else begin
					err_next = 1'b1;
				end
				clr_bit = (cnt_next == '0);
			end
			FUNC_ADD: begin
				set_bit = 1'b1;
				if ((cnt_cur < lim) && ((lim - cnt_cur) > amt_s1)) begin
					cnt_next = cnt_cur + amt_s1;
				end else begin
					cnt_next = lim;
					err_next = 1'b1;
				end
			end
			FUNC_SUB: begin
				if (cnt_cur >= amt_s1) begin
					cnt_next = cnt_cur - amt_s1;
				end else begin
					cnt_next = '0;
					err_next = 1'b1;
				end
				clr_bit = (cnt_next == '0);
			end
			default: begin
				cnt_next = cnt_cur;
			end
		endcase
	end

	always_comb begin
		bitmap_next = bitmap_q;
		if (in_range_s1) begin
			if (set_bit) begin
				bitmap_next[idx_s1] = 1'b1;
			end else if (clr_bit) begin
				bitmap_next[idx_s1] = 1'b0;
			end
		end
	end

	assign bitmap_ext = BW'(bitmap_next);
	assign cnt_ext    = XW'(cnt_next);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			active_levels_q <= bitmap_ext[ACTIVE_W-1:0];
			if (in_range_s1) begin
				level_active_q <= bitmap_next[idx_s1];
				new_count_q    <= cnt_ext[OCOUNT_W-1:0];
				range_error_q  <= err_next;
			end else begin
				level_active_q <= 1'b0;
				new_count_q    <= '0;
				range_error_q  <= 1'b0;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign level_active  = level_active_q;
	assign active_levels = active_levels_q;
	assign new_count     = new_count_q;
	assign range_error   = range_error_q;

	// ---------------- assertions ----------------
	// a non-zero count only exists on a level whose bit is set
	a_count_implies_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (new_count != '0) |-> level_active)
		else $error("non-zero count on an inactive level");

	// an error that leaves the bit clear is a clamp at zero
	a_clamp_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && range_error && !level_active |-> new_count == '0)
		else $error("clamp error with non-zero count");

	// a completed update always leaves a result waiting or taken
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> result_valid)
		else $error("completed item produced no result");

endmodule
